@@ hdl/robin_hood_hash_table_macros.svh @@
// ----------------------------------------------------------------------------
// robin hood hash table assertion macros
// wrappers around concurrent assertions, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ROBIN_HOOD_HASH_TABLE_MACROS_SVH
`define ROBIN_HOOD_HASH_TABLE_MACROS_SVH
`ifndef SYNTHESIS
`define RH_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define RH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RH_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RH_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/rhht_pkg.sv @@
// ----------------------------------------------------------------------------
// rhht_pkg
// shared constants and types of the robin hood hash table
// ----------------------------------------------------------------------------
package rhht_pkg;
    localparam int TABLE_BITS_DEF  = 8;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam logic [63:0] HASH_MUL_A = 64'hf1357aea2e62a9c5;
    localparam logic [63:0] HASH_MUL_B = 64'h9e3779b97f4a7c15;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_FIND   = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;
endpackage

@@ hdl/rhht_hash.sv @@
// ----------------------------------------------------------------------------
// rhht_hash
// multi-cycle home slot hash: two 64-bit products from 32x32 partial products
// ----------------------------------------------------------------------------
module rhht_hash import rhht_pkg::*; #(
    parameter int TABLE_BITS = TABLE_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [63:0]           key,
    input  logic [63:0]           seed,
    output logic                  done,
    output logic [TABLE_BITS-1:0] home
);
    // step: key plus seed on start, then 3 partial products per multiply, low 64 bits only
    logic [63:0] acc_reg, acc_next;
    logic [63:0] opd_reg, opd_next;
    logic [63:0] mul_reg, mul_next;
    logic [2:0]  step_reg, step_next;
    logic        busy_reg, busy_next;
    logic        pass_reg, pass_next;
    logic        done_reg, done_next;
    logic [31:0] pa, pb;
    logic [63:0] prod;

    always_comb begin
        case (step_reg)
            3'd0:    begin pa = opd_reg[31:0];  pb = mul_reg[31:0];  end
            3'd1:    begin pa = opd_reg[31:0];  pb = mul_reg[63:32]; end
            default: begin pa = opd_reg[63:32]; pb = mul_reg[31:0];  end
        endcase
    end
    assign prod = {32'd0, pa} * {32'd0, pb};

    always_comb begin
        acc_next  = acc_reg;
        opd_next  = opd_reg;
        mul_next  = mul_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        pass_next = pass_reg;
        done_next = 1'b0;
        if (start) begin
            opd_next  = key + seed;
            mul_next  = HASH_MUL_A;
            acc_next  = 64'd0;
            step_next = 3'd0;
            busy_next = 1'b1;
            pass_next = 1'b0;
        end else if (busy_reg) begin
            case (step_reg)
                3'd0: begin
                    acc_next  = acc_reg + prod;
                    step_next = 3'd1;
                end
                3'd1: begin
                    acc_next  = acc_reg + {prod[31:0], 32'd0};
                    step_next = 3'd2;
                end
                default: begin
                    acc_next  = 64'd0;
                    opd_next  = acc_reg + {prod[31:0], 32'd0};
                    mul_next  = HASH_MUL_B;
                    step_next = 3'd0;
                    if (pass_reg) begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    pass_next = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            pass_reg <= 1'b0;
            step_reg <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            pass_reg <= pass_next;
            step_reg <= step_next;
        end
        acc_reg <= acc_next;
        opd_reg <= opd_next;
        mul_reg <= mul_next;
    end

    assign done = done_reg;
    assign home = opd_reg[63 -: TABLE_BITS];
endmodule

@@ hdl/rhht_slot_mem.sv @@
// ----------------------------------------------------------------------------
// rhht_slot_mem
// slot store: key, data word and probe distance, one port, registered read
// ----------------------------------------------------------------------------
module rhht_slot_mem import rhht_pkg::*; #(
    parameter int TABLE_BITS  = TABLE_BITS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic [TABLE_BITS-1:0]  addr,
    input  logic                   we,
    input  logic [63:0]            wkey,
    input  logic [VALUE_WIDTH-1:0] wval,
    input  logic [TABLE_BITS:0]    wdist,
    output logic [63:0]            rkey,
    output logic [VALUE_WIDTH-1:0] rval,
    output logic [TABLE_BITS:0]    rdist
);
    localparam int DEPTH = 1 << TABLE_BITS;
    localparam int W = 64 + VALUE_WIDTH;
    logic [W-1:0]          kv_mem [DEPTH];
    logic [TABLE_BITS:0]   dist_mem [DEPTH];
    logic [W-1:0]          kv_reg;
    logic [TABLE_BITS:0]   dist_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            kv_mem[addr]   <= {wval, wkey};
            dist_mem[addr] <= wdist;
        end
        kv_reg   <= kv_mem[addr];
        dist_reg <= dist_mem[addr];
    end

    assign rkey  = kv_reg[63:0];
    assign rval  = kv_reg[W-1:64];
    assign rdist = dist_reg;
endmodule

@@ hdl/robin_hood_hash_table.sv @@
// ----------------------------------------------------------------------------
// robin_hood_hash_table
// fixed-size robin hood hash table, backward-shift delete, one result each
// ----------------------------------------------------------------------------
// channel   dir  handshake                 payload
// s_        in   s_tvalid / s_tready       s_tuser req_type, s_tdata key,value
// m_        out  m_tvalid / m_tready       m_tuser status, m_tdata value,count
// cfg_      in   cfg_valid / cfg_ready     cfg_data hash_seed
// one request at a time: the hash runs after the accept, then a read and a
// compare/write on the single memory port for each probed or shifted slot,
// then the output register is loaded
// after reset and after clear a sweep zeroes every distance while s_tready
// stays low
// a result waits in the output register; the next request is taken meanwhile
// ----------------------------------------------------------------------------
`include "robin_hood_hash_table_macros.svh"
module robin_hood_hash_table import rhht_pkg::*; #(
    parameter int TABLE_BITS  = TABLE_BITS_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,   // key[63:0], value[95:64]
    input  logic [1:0]    s_tuser,   // req_type
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [39:0]   m_tdata,   // found_value[31:0], entry_count[39:32]
    output logic [1:0]    m_tuser,   // status
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [63:0]   cfg_data
);
    localparam int SLOTS = 1 << TABLE_BITS;
    localparam int LIMIT = SLOTS - SLOTS / 8;
    localparam int VW = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
    localparam logic [TABLE_BITS:0] CNT_LIMIT = (TABLE_BITS+1)'(LIMIT);

    typedef enum logic [8:0] {
        S_SWEEP = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_HASH  = 9'b000000100,
        S_READ  = 9'b000001000,
        S_INS   = 9'b000010000,
        S_FIND  = 9'b000100000,
        S_SHIFT = 9'b001000000,
        S_DONE  = 9'b010000000,
        S_REPLY = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [63:0] seed_reg;
    logic [TABLE_BITS-1:0] idx_reg, idx_next, dest_reg, dest_next;
    logic [TABLE_BITS:0]   dist_reg, dist_next, cnt_reg, cnt_next;
    logic [63:0] key_reg, key_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    req_t req_reg, req_next;
    logic remove_found_reg, remove_found_next;
    logic [TABLE_BITS:0] steps_reg, steps_next;
    logic [1:0] res_status_reg, res_status_next;
    logic [31:0] res_val_reg, res_val_next;
    logic out_valid_reg, out_valid_next;
    logic [1:0] out_status_reg, out_status_next;
    logic [31:0] out_val_reg, out_val_next;
    logic [7:0] out_cnt_reg, out_cnt_next;

    logic hash_start, hash_done;
    logic [TABLE_BITS-1:0] home;
    logic mem_we;
    logic [TABLE_BITS-1:0] mem_addr;
    logic [63:0] mem_wkey, rkey;
    logic [VALUE_WIDTH-1:0] mem_wval, rval;
    logic [TABLE_BITS:0] mem_wdist, rdist;

    logic s_acc;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // hash starts on the accept edge, so it takes the key straight from the request
    rhht_hash #(.TABLE_BITS(TABLE_BITS)) u_hash (
        .aclk(aclk), .aresetn(aresetn), .start(hash_start),
        .key(key_next), .seed(seed_reg), .done(hash_done), .home(home)
    );

    rhht_slot_mem #(.TABLE_BITS(TABLE_BITS), .VALUE_WIDTH(VALUE_WIDTH)) u_mem (
        .aclk(aclk), .addr(mem_addr), .we(mem_we), .wkey(mem_wkey),
        .wval(mem_wval), .wdist(mem_wdist), .rkey(rkey), .rval(rval),
        .rdist(rdist)
    );

    always_comb begin
        state_next        = state_reg;
        idx_next          = idx_reg;
        dest_next         = dest_reg;
        dist_next         = dist_reg;
        cnt_next          = cnt_reg;
        key_next          = key_reg;
        val_next          = val_reg;
        req_next          = req_reg;
        remove_found_next = remove_found_reg;
        steps_next        = steps_reg;
        res_status_next   = res_status_reg;
        res_val_next      = res_val_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_status_next   = out_status_reg;
        out_val_next      = out_val_reg;
        out_cnt_next      = out_cnt_reg;
        hash_start        = 1'b0;
        mem_we            = 1'b0;
        mem_addr          = idx_reg;
        mem_wkey          = key_reg;
        mem_wval          = val_reg;
        mem_wdist         = dist_reg;
        case (state_reg)
            S_SWEEP: begin
                mem_we    = 1'b1;
                mem_wdist = '0;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == {TABLE_BITS{1'b1}}) begin
                    state_next = (req_reg == REQ_CLEAR) ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_acc) begin
                    key_next  = s_tdata[63:0];
                    val_next  = VALUE_WIDTH'(s_tdata[64 +: VW]);
                    req_next  = req_t'(s_tuser);
                    dist_next = (TABLE_BITS+1)'(1);
                    steps_next = '0;
                    remove_found_next = 1'b0;
                    res_status_next = ST_OK;
                    res_val_next = '0;
                    case (req_t'(s_tuser))
                        REQ_CLEAR: begin
                            cnt_next = '0;
                            idx_next = '0;
                            state_next = S_SWEEP;
                        end
                        REQ_INSERT: begin
                            if (cnt_reg + 1'b1 >= CNT_LIMIT) begin
                                res_status_next = ST_FULL;
                                state_next = S_DONE;
                            end else begin
                                hash_start = 1'b1;
                                state_next = S_HASH;
                            end
                        end
                        default: begin
                            if (cnt_reg == '0) begin
                                res_status_next = ST_NOT_FOUND;
                                state_next = S_DONE;
                            end else begin
                                hash_start = 1'b1;
                                state_next = S_HASH;
                            end
                        end
                    endcase
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    idx_next = home;
                    state_next = S_READ;
                end
            end
            S_READ: begin
                // address idx_reg presented; data arrives next cycle
                state_next = (req_reg == REQ_INSERT) ? S_INS :
                             (remove_found_reg ? S_SHIFT : S_FIND);
            end
            S_INS: begin
                steps_next = steps_reg + 1'b1;
                if (rdist == '0) begin
                    mem_we = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                    state_next = S_DONE;
                end else if (dist_reg > rdist) begin
                    mem_we = 1'b1;
                    key_next = rkey;
                    val_next = rval;
                    dist_next = rdist + 1'b1;
                    idx_next = idx_reg + 1'b1;
                    state_next = S_READ;
                end else if (rkey == key_reg) begin
                    res_status_next = ST_DUPLICATE;
                    state_next = S_DONE;
                end else begin
                    dist_next = dist_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                    state_next = S_READ;
                end
                if (steps_reg == (TABLE_BITS+1)'(SLOTS - 1) && state_next == S_READ) begin
                    res_status_next = ST_FULL;
                    state_next = S_DONE;
                end
            end
            S_FIND: begin
                steps_next = steps_reg + 1'b1;
                if (dist_reg > rdist) begin
                    res_status_next = ST_NOT_FOUND;
                    state_next = S_DONE;
                end else if (rkey == key_reg) begin
                    if (req_reg == REQ_FIND) begin
                        res_val_next = 32'(rval);
                        state_next = S_DONE;
                    end else begin
                        remove_found_next = 1'b1;
                        dest_next = idx_reg;
                        idx_next = idx_reg + 1'b1;
                        steps_next = '0;
                        state_next = S_READ;
                    end
                end else begin
                    dist_next = dist_reg + 1'b1;
                    idx_next = idx_reg + 1'b1;
                    state_next = S_READ;
                    if (steps_reg == (TABLE_BITS+1)'(SLOTS - 1)) begin
                        res_status_next = ST_NOT_FOUND;
                        state_next = S_DONE;
                    end
                end
            end
            S_SHIFT: begin
                // move the next entry back one slot, or close the hole
                mem_we = 1'b1;
                mem_addr = dest_reg;
                steps_next = steps_reg + 1'b1;
                if (rdist <= (TABLE_BITS+1)'(1) ||
                    steps_reg == (TABLE_BITS+1)'(SLOTS - 1)) begin
                    mem_wdist = '0;
                    cnt_next = cnt_reg - 1'b1;
                    state_next = S_DONE;
                end else begin
                    mem_wkey = rkey;
                    mem_wval = rval;
                    mem_wdist = rdist - 1'b1;
                    dest_next = idx_reg;
                    idx_next = idx_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            S_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    out_valid_next = 1'b1;
                    out_status_next = res_status_reg;
                    out_val_next = res_val_reg;
                    out_cnt_next = 8'(cnt_reg);
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_SWEEP;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            req_reg       <= REQ_INSERT;
            out_valid_reg <= 1'b0;
            seed_reg      <= '0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            req_reg       <= req_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid) begin
                seed_reg <= cfg_data;
            end
        end
        dest_reg         <= dest_next;
        dist_reg         <= dist_next;
        key_reg          <= key_next;
        val_reg          <= val_next;
        remove_found_reg <= remove_found_next;
        steps_reg        <= steps_next;
        res_status_reg   <= res_status_next;
        res_val_reg      <= res_val_next;
        out_status_reg   <= out_status_next;
        out_val_reg      <= out_val_next;
        out_cnt_reg      <= out_cnt_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {out_cnt_reg, out_val_reg};

    `RH_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, cnt_reg < CNT_LIMIT)
    `RH_ASSERT_IMPL(a_ready_idle, aclk, aresetn, s_tready, !hash_done)
    `RH_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_acc, !s_tready)
    `RH_ASSERT_IMPL(a_shift_write, aclk, aresetn, state_reg == S_SHIFT, mem_we)
endmodule
